### src/brb_pkg.sv
// ----------------------------------------------------------------------------
// Byte ring buffer package
// Item kinds, the command record that the front end hands to the back end,
// and the fixed field widths of the block.
// ----------------------------------------------------------------------------
package brb_pkg;

    localparam int unsigned REQ_W   = 7;
    localparam int unsigned COUNT_W = 9;

    // The per-burst store count saturates at the top of its field.
    localparam logic [COUNT_W-1:0] BURST_MAX = 9'd511;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_PEEK  = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       data_byte;
        logic             burst_end;
        logic [REQ_W-1:0] req_len;
    } cmd_t;

endpackage

### src/brb_front.sv
// ----------------------------------------------------------------------------
// Byte ring buffer front end
// Accepts items, decodes the kind, clamps the request length and queues the
// resulting commands for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module brb_front #(
    parameter int unsigned MAX_REQUEST = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [1:0]                kind,
    input  logic [7:0]                data_byte,
    input  logic                      burst_end,
    input  logic [brb_pkg::REQ_W-1:0] request_length,
    output logic                      busy,
    output logic                      cmd_valid,
    output brb_pkg::cmd_t             cmd,
    input  logic                      cmd_ready
);

    localparam logic [brb_pkg::REQ_W-1:0] REQ_CAP = brb_pkg::REQ_W'(MAX_REQUEST);

    brb_pkg::cmd_t q_mem [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;

    brb_pkg::cmd_t new_cmd;
    logic          push;
    logic          pop;

    // Classify the incoming item; only reads and peeks use the length.
    always_comb
    begin
        new_cmd.kind      = brb_pkg::kind_t'(kind);
        new_cmd.data_byte = data_byte;
        new_cmd.burst_end = burst_end;
        new_cmd.req_len   = (request_length > REQ_CAP) ? REQ_CAP : request_length;
    end

    assign busy      = (cnt_reg == 2'd2);
    assign push      = start && !busy;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### src/brb_back.sv
// ----------------------------------------------------------------------------
// Byte ring buffer back end
// Owns the byte storage and the head, tail and fill count. Executes one
// command at a time and streams read bytes out one per cycle.
// ----------------------------------------------------------------------------
module brb_back #(
    parameter int unsigned BUFFER_BYTES = 512
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  brb_pkg::cmd_t               cmd,
    output logic                        cmd_ready,
    output logic                        done,
    output logic [7:0]                  out_byte,
    output logic                        byte_valid,
    output logic                        last_of_run,
    output logic [brb_pkg::COUNT_W-1:0] moved_count,
    output logic [brb_pkg::COUNT_W-1:0] used_count,
    output logic [brb_pkg::COUNT_W-1:0] free_count
);

    localparam int unsigned PW   = $clog2(BUFFER_BYTES);
    localparam int unsigned CMPW = (PW > brb_pkg::REQ_W) ? PW : brb_pkg::REQ_W;
    localparam logic [PW-1:0] TOP_IDX  = PW'(BUFFER_BYTES - 1);
    localparam logic [PW:0]   BUF_SIZE = (PW+1)'(BUFFER_BYTES);

    localparam int unsigned CW = brb_pkg::COUNT_W;
    localparam int unsigned RW = brb_pkg::REQ_W;

    logic [7:0] mem [BUFFER_BYTES];
    logic [7:0] rd_data_reg;

    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [PW-1:0] used_reg, used_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [CW-1:0] burst_reg, burst_next;
    logic [CW-1:0] hold_moved_reg, hold_moved_next;
    logic [RW-1:0] left_reg, left_next;
    logic          active_reg, active_next;

    logic          done_reg;
    logic          bvalid_reg;
    logic          last_reg;
    logic [CW-1:0] moved_reg;
    logic [CW-1:0] used_out_reg;
    logic [CW-1:0] free_out_reg;

    logic          take;
    logic          mem_we;
    logic          rd_en;
    logic [PW-1:0] rd_addr;
    logic          emit;
    logic          e_valid;
    logic          e_last;
    logic [CW-1:0] e_moved;
    logic [RW-1:0] n_len;
    logic [CW-1:0] burst_inc;
    logic [PW:0]   head_sum;

    function automatic logic [PW-1:0] step_idx(input logic [PW-1:0] p);
        step_idx = (p == TOP_IDX) ? '0 : p + 1'b1;
    endfunction

    assign cmd_ready = !active_reg;
    assign take      = cmd_valid && cmd_ready;

    // Bytes actually returned: the clamped request, or what is held if less.
    assign n_len     = (CMPW'(cmd.req_len) > CMPW'(used_reg)) ? RW'(used_reg) : cmd.req_len;
    assign burst_inc = (burst_reg == brb_pkg::BURST_MAX) ? burst_reg : burst_reg + 1'b1;
    assign head_sum  = (PW+1)'(head_reg) + (PW+1)'(n_len);

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        used_next       = used_reg;
        pos_next        = pos_reg;
        burst_next      = burst_reg;
        hold_moved_next = hold_moved_reg;
        left_next       = left_reg;
        active_next     = active_reg;
        mem_we          = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = pos_reg;
        emit            = 1'b0;
        e_valid         = 1'b0;
        e_last          = 1'b0;
        e_moved         = '0;

        if (active_reg)
        begin
            rd_en    = 1'b1;
            emit     = 1'b1;
            e_valid  = 1'b1;
            e_last   = (left_reg == RW'(1));
            e_moved  = hold_moved_reg;
            pos_next = step_idx(pos_reg);
            left_next = left_reg - 1'b1;
            if (left_reg == RW'(1))
            begin
                active_next = 1'b0;
            end
        end
        else if (take)
        begin
            case (cmd.kind)
                brb_pkg::KIND_WRITE:
                begin
                    if (used_reg != TOP_IDX)
                    begin
                        mem_we     = 1'b1;
                        tail_next  = step_idx(tail_reg);
                        used_next  = used_reg + 1'b1;
                        burst_next = burst_inc;
                    end
                    if (cmd.burst_end)
                    begin
                        emit       = 1'b1;
                        e_last     = 1'b1;
                        e_moved    = (used_reg != TOP_IDX) ? burst_inc : burst_reg;
                        burst_next = '0;
                    end
                end
                brb_pkg::KIND_CLEAR:
                begin
                    tail_next = head_reg;
                    used_next = '0;
                    emit      = 1'b1;
                    e_last    = 1'b1;
                end
                brb_pkg::KIND_READ, brb_pkg::KIND_PEEK:
                begin
                    emit = 1'b1;
                    if (n_len == '0)
                    begin
                        e_last = 1'b1;
                    end
                    else
                    begin
                        rd_en           = 1'b1;
                        rd_addr         = head_reg;
                        e_valid         = 1'b1;
                        e_last          = (n_len == RW'(1));
                        e_moved         = CW'(n_len);
                        hold_moved_next = CW'(n_len);
                        left_next       = n_len - 1'b1;
                        active_next     = (n_len != RW'(1));
                        pos_next        = step_idx(head_reg);
                        if (cmd.kind == brb_pkg::KIND_READ)
                        begin
                            head_next = (head_sum >= BUF_SIZE) ? PW'(head_sum - BUF_SIZE)
                                                               : PW'(head_sum);
                            used_next = used_reg - PW'(n_len);
                        end
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    // Storage: one write port at the tail, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[tail_reg] <= cmd.data_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        bvalid_reg   <= e_valid;
        last_reg     <= e_last;
        moved_reg    <= e_moved;
        used_out_reg <= CW'(used_next);
        free_out_reg <= CW'(TOP_IDX - used_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            tail_reg       <= '0;
            used_reg       <= '0;
            pos_reg        <= '0;
            burst_reg      <= '0;
            hold_moved_reg <= '0;
            left_reg       <= '0;
            active_reg     <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            used_reg       <= used_next;
            pos_reg        <= pos_next;
            burst_reg      <= burst_next;
            hold_moved_reg <= hold_moved_next;
            left_reg       <= left_next;
            active_reg     <= active_next;
            done_reg       <= emit;
        end
    end

    assign done        = done_reg;
    assign out_byte    = bvalid_reg ? rd_data_reg : 8'd0;
    assign byte_valid  = bvalid_reg;
    assign last_of_run = last_reg;
    assign moved_count = moved_reg;
    assign used_count  = used_out_reg;
    assign free_count  = free_out_reg;

endmodule

### src/byte_ring_buffer.sv
// ----------------------------------------------------------------------------
// Byte ring buffer
// Circular byte FIFO that keeps one slot empty, with burst writes, reads,
// peeks and clear, built as a front end and a back end joined by a queue.
// ----------------------------------------------------------------------------
// An item is taken on a rising edge where start is high and busy is low.
// Results appear on the result ports for a single cycle, flagged by done, and
// the receiver cannot hold them off. The buffer has BUFFER_BYTES slots and
// holds at most BUFFER_BYTES-1 bytes. A write stores one byte per item unless
// the buffer is full; only the write that ends a burst gives a result, which
// reports how many bytes the burst stored. Clear gives one result. A read or
// peek of n bytes (the request clamped to MAX_REQUEST and to the fill level)
// returns them one byte per cycle, set by the single read port of the byte
// storage; an empty answer gives one result. Each result leaves on done in
// the cycle after the back end issues it. The front end queues up to two
// items, so start may be asserted while a long read is still streaming; busy
// rises only when that queue is full. Every result carries the used and free
// counts that hold after its item. The storage needs no clearing after reset.
// ----------------------------------------------------------------------------
module byte_ring_buffer #(
    parameter int unsigned BUFFER_BYTES = 512,
    parameter int unsigned MAX_REQUEST  = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  kind,
    input  logic [7:0]                  data_byte,
    input  logic                        burst_end,
    input  logic [brb_pkg::REQ_W-1:0]   request_length,
    output logic                        done,
    output logic [7:0]                  out_byte,
    output logic                        byte_valid,
    output logic                        last_of_run,
    output logic [brb_pkg::COUNT_W-1:0] moved_count,
    output logic [brb_pkg::COUNT_W-1:0] used_count,
    output logic [brb_pkg::COUNT_W-1:0] free_count
);

    logic          cmd_valid;
    logic          cmd_ready;
    brb_pkg::cmd_t cmd;

    // The front end decodes items and buffers them so the host sees the
    // queue, not the back end, as its flow control.
    brb_front #(
        .MAX_REQUEST (MAX_REQUEST)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .kind           (kind),
        .data_byte      (data_byte),
        .burst_end      (burst_end),
        .request_length (request_length),
        .busy           (busy),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_ready      (cmd_ready)
    );

    // The back end owns the storage and pointers and produces all results.
    brb_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_ready   (cmd_ready),
        .done        (done),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .last_of_run (last_of_run),
        .moved_count (moved_count),
        .used_count  (used_count),
        .free_count  (free_count)
    );

    // A result without a byte is always the only, and so the last, result.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && !byte_valid |-> last_of_run)
        else $error("byte-less result not marked last");

    // Used plus free always equals BUFFER_BYTES-1, the most bytes the buffer holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (brb_pkg::COUNT_W'(used_count + free_count) ==
                  brb_pkg::COUNT_W'(BUFFER_BYTES - 1)))
        else $error("used and free counts disagree with capacity");

    // A returned byte belongs to a non-empty answer.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && byte_valid |-> moved_count != '0)
        else $error("byte returned with zero moved count");

endmodule
